// ===== rtl/tbgd_pkg.sv =====
// Package for the two-button gesture decoder.
// Holds event codes, register indexes, register reset values and the config struct.
// No dependencies.
package tbgd_pkg;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned APB_ADDR_W  = 4;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned NOW_W       = 32;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        TOP_EV_NONE = 2'd0,
        TOP_EV_MODE = 2'd1,
        TOP_EV_ADD  = 2'd2
    } t_top_ev;

    typedef enum logic [2:0] {
        BOT_EV_NONE          = 3'd0,
        BOT_EV_STARTSTOP     = 3'd1,
        BOT_EV_RESET         = 3'd2,
        BOT_EV_SETUP         = 3'd3,
        BOT_EV_SETUP_RESTORE = 3'd4,
        BOT_EV_PERSIST       = 3'd5,
        BOT_EV_SOFTOFF       = 3'd6
    } t_bot_ev;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_PRESS   = 2'd0,
        REG_SETUP_HOLD   = 2'd1,
        REG_SOFT_OFF     = 2'd2,
        REG_BOTH_CONFIRM = 2'd3
    } t_reg_idx;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1500;
    localparam logic [CFG_W-1:0] SETUP_HOLD_RST   = 16'd3000;
    localparam logic [CFG_W-1:0] SOFT_OFF_RST     = 16'd3000;
    localparam logic [CFG_W-1:0] BOTH_CONFIRM_RST = 16'd100;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] setup_hold_ms;
        logic [CFG_W-1:0] soft_off_hold_ms;
        logic [CFG_W-1:0] both_confirm_ms;
    } t_cfg;

endpackage

// ===== rtl/tbgd_cfg_regs.sv =====
// Configuration register file of the gesture decoder, written and read over APB.
// Depends on tbgd_pkg.
module tbgd_cfg_regs
    import tbgd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ms    <= LONG_PRESS_RST;
            r_cfg.setup_hold_ms    <= SETUP_HOLD_RST;
            r_cfg.soft_off_hold_ms <= SOFT_OFF_RST;
            r_cfg.both_confirm_ms  <= BOTH_CONFIRM_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_LONG_PRESS:   r_cfg.long_press_ms    <= pwdata[CFG_W-1:0];
                REG_SETUP_HOLD:   r_cfg.setup_hold_ms    <= pwdata[CFG_W-1:0];
                REG_SOFT_OFF:     r_cfg.soft_off_hold_ms <= pwdata[CFG_W-1:0];
                REG_BOTH_CONFIRM: r_cfg.both_confirm_ms  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LONG_PRESS:   prdata = APB_DATA_W'(r_cfg.long_press_ms);
            REG_SETUP_HOLD:   prdata = APB_DATA_W'(r_cfg.setup_hold_ms);
            REG_SOFT_OFF:     prdata = APB_DATA_W'(r_cfg.soft_off_hold_ms);
            REG_BOTH_CONFIRM: prdata = APB_DATA_W'(r_cfg.both_confirm_ms);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== rtl/tbgd_core.sv =====
// Gesture state and event decode: press edges, hold times and one-shot flags.
// State advances once per stepped sample. Depends on tbgd_pkg.
module tbgd_core
    import tbgd_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_top,
    input  logic             i_bot,
    input  logic [NOW_W-1:0] i_now_ms,
    input  logic             i_setup,
    input  logic             i_countdown,
    input  t_cfg             i_cfg,
    output t_top_ev          o_top_ev,
    output t_bot_ev          o_bot_ev
);

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] long_t, setup_t, soft_t, confirm_t;

    logic                 r_prev_top, n_prev_top;
    logic                 r_prev_bot, n_prev_bot;
    logic [TIME_BITS-1:0] r_top_time, n_top_time;
    logic [TIME_BITS-1:0] r_bot_time, n_bot_time;
    logic [TIME_BITS-1:0] r_both_time, n_both_time;
    logic                 r_both_valid, n_both_valid;
    logic                 r_top_long, n_top_long;
    logic                 r_bot_long, n_bot_long;
    logic                 r_reset_done, n_reset_done;
    logic                 r_soft_done, n_soft_done;

    logic [TIME_BITS-1:0] both_held, top_held, bot_held;

    // Timestamps are kept modulo 2^TIME_BITS; differences wrap naturally.
    assign now       = TIME_BITS'(i_now_ms);
    assign long_t    = TIME_BITS'(i_cfg.long_press_ms);
    assign setup_t   = TIME_BITS'(i_cfg.setup_hold_ms);
    assign soft_t    = TIME_BITS'(i_cfg.soft_off_hold_ms);
    assign confirm_t = TIME_BITS'(i_cfg.both_confirm_ms);

    // Start times as seen by this sample: a fresh press edge restarts the clock.
    assign n_both_time = (i_top && i_bot && !r_both_valid) ? now : r_both_time;
    assign n_top_time  = (i_top && !i_bot && !r_prev_top) ? now : r_top_time;
    assign n_bot_time  = (i_bot && !i_top && !r_prev_bot) ? now : r_bot_time;
    assign both_held   = now - n_both_time;
    assign top_held    = now - n_top_time;
    assign bot_held    = now - n_bot_time;

    always_comb begin
        o_top_ev     = TOP_EV_NONE;
        o_bot_ev     = BOT_EV_NONE;
        n_prev_top   = i_top;
        n_prev_bot   = i_bot;
        n_both_valid = r_both_valid;
        n_top_long   = r_top_long;
        n_bot_long   = r_bot_long;
        n_reset_done = r_reset_done;
        n_soft_done  = r_soft_done;

        if (i_top && i_bot) begin
            n_both_valid = 1'b1;
            if (both_held >= confirm_t) begin
                n_top_long = 1'b1;
                n_bot_long = 1'b1;
            end
            if (!r_soft_done && both_held >= soft_t) begin
                n_soft_done = 1'b1;
                o_bot_ev    = BOT_EV_SOFTOFF;
            end
        end else begin
            n_both_valid = 1'b0;
            n_soft_done  = 1'b0;
        end

        if (i_top && !i_bot) begin
            if (!r_prev_top) begin
                n_top_long = 1'b0;
            end
            if (!i_setup && !n_top_long && top_held >= long_t) begin
                n_top_long = 1'b1;
                o_top_ev   = TOP_EV_MODE;
            end
        end

        if (i_bot && !i_top) begin
            if (!r_prev_bot) begin
                n_bot_long   = 1'b0;
                n_reset_done = 1'b0;
            end
            if (!n_bot_long) begin
                if (i_setup && bot_held >= long_t) begin
                    n_bot_long = 1'b1;
                    o_bot_ev   = BOT_EV_SETUP;
                end else if (!i_setup && bot_held >= setup_t) begin
                    n_bot_long = 1'b1;
                    o_bot_ev   = n_reset_done ? BOT_EV_SETUP_RESTORE : BOT_EV_SETUP;
                end else if (!i_setup && !n_reset_done && bot_held >= long_t) begin
                    n_reset_done = 1'b1;
                    o_bot_ev     = BOT_EV_RESET;
                end
            end
        end

        // Short releases; the long flags are untouched above when neither is held.
        if (!i_top && r_prev_top && !i_bot) begin
            if (!r_top_long && !i_setup && i_countdown) begin
                o_top_ev = TOP_EV_ADD;
            end
        end

        if (!i_bot && r_prev_bot && !i_top) begin
            if (!r_bot_long && !i_setup) begin
                o_bot_ev = r_reset_done ? BOT_EV_PERSIST : BOT_EV_STARTSTOP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_top   <= 1'b0;
            r_prev_bot   <= 1'b0;
            r_top_time   <= '0;
            r_bot_time   <= '0;
            r_both_time  <= '0;
            r_both_valid <= 1'b0;
            r_top_long   <= 1'b0;
            r_bot_long   <= 1'b0;
            r_reset_done <= 1'b0;
            r_soft_done  <= 1'b0;
        end else if (i_step) begin
            r_prev_top   <= n_prev_top;
            r_prev_bot   <= n_prev_bot;
            r_top_time   <= n_top_time;
            r_bot_time   <= n_bot_time;
            r_both_time  <= n_both_time;
            r_both_valid <= n_both_valid;
            r_top_long   <= n_top_long;
            r_bot_long   <= n_bot_long;
            r_reset_done <= n_reset_done;
            r_soft_done  <= n_soft_done;
        end
    end

endmodule

// ===== rtl/two_button_gesture_decoder.sv =====
// Two-button gesture decoder, top level. Depends on tbgd_pkg, tbgd_cfg_regs, tbgd_core.
// An accepted input beat passes through the input register and then the output register.
// Throughput: one sample per cycle unless the output stalls; the input register feeds the
// event logic, whose result goes to the output register; a stall holds the input stage.
// Reset (i_rst_n low, synchronous) empties both stages, clears all gesture state and
// loads the configuration registers with their default hold times.
module two_button_gesture_decoder
    import tbgd_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream. tdata from bit 0: top_down, bottom_down, now_ms[31:0],
    // setup_mode, countdown_mode, then four zero bits.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result stream. tdata from bit 0: top_event[1:0], bottom_event[2:0],
    // then three zero bits.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    t_cfg cfg;

    // Input stage: one registered sample waiting for the event logic.
    logic             r_in_valid;
    logic             r_in_top;
    logic             r_in_bot;
    logic [NOW_W-1:0] r_in_now;
    logic             r_in_set_mode;
    logic             r_in_countdown;

    // Output stage: the registered result beat.
    logic             r_out_valid;
    t_top_ev          r_out_top_ev;
    t_bot_ev          r_out_bot_ev;

    t_top_ev          top_ev;
    t_bot_ev          bot_ev;
    logic             out_free;
    logic             advance;
    logic             in_accept;

    // The output register can take a new result when empty or being drained this cycle.
    // Gesture state only moves when the sample in the input stage moves on, so state
    // updates follow the order of accepted beats exactly.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    tbgd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tbgd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_top       (r_in_top),
        .i_bot       (r_in_bot),
        .i_now_ms    (r_in_now),
        .i_setup     (r_in_set_mode),
        .i_countdown (r_in_countdown),
        .i_cfg       (cfg),
        .o_top_ev    (top_ev),
        .o_bot_ev    (bot_ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Sample payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_top       <= s_axis_tdata[0];
            r_in_bot       <= s_axis_tdata[1];
            r_in_now       <= s_axis_tdata[NOW_W+1:2];
            r_in_set_mode  <= s_axis_tdata[NOW_W+2];
            r_in_countdown <= s_axis_tdata[NOW_W+3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_top_ev <= top_ev;
            r_out_bot_ev <= bot_ev;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_bot_ev, r_out_top_ev};

endmodule
